[src/bsi_pkg.sv]
// Package: register map and fixed widths for the broadcast source index unit.
`timescale 1ns / 1ps
`default_nettype none
package bsi_pkg;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int RANK_BITS      = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_RANK    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_RANK    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_EXTENTS = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_EXTENTS = 2'd3;

endpackage
`default_nettype wire

[src/bsi_div_cell.sv]
// One restoring division step of the index chain, with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none
module bsi_div_cell
   import bsi_pkg::*;
#(
   parameter int INDEX_BITS  = 32,
   parameter int EXTENT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [EXTENT_BITS-1:0] divisor,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire logic [INDEX_BITS-1:0]  in_word,
   input  wire logic [EXTENT_BITS-1:0] in_rem,
   input  wire logic [INDEX_BITS-1:0]  in_src,
   input  wire logic [INDEX_BITS-1:0]  in_pend,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      logic [INDEX_BITS-1:0]  out_word,
   output      logic [EXTENT_BITS-1:0] out_rem,
   output      logic [INDEX_BITS-1:0]  out_src,
   output      logic [INDEX_BITS-1:0]  out_pend
);

   logic                   valid_ff, valid_in;
   logic [INDEX_BITS-1:0]  word_ff, word_in;
   logic [EXTENT_BITS-1:0] rem_ff, rem_in;
   logic [INDEX_BITS-1:0]  src_ff, pend_ff;
   logic [EXTENT_BITS:0]   trial;
   logic                   fits;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // shift next dividend bit into the partial remainder, subtract if it fits
   always_comb begin
      trial   = {in_rem, in_word[INDEX_BITS-1]};
      fits    = trial >= {1'b0, divisor};
      rem_in  = fits ? EXTENT_BITS'(trial - {1'b0, divisor}) : trial[EXTENT_BITS-1:0];
      word_in = {in_word[INDEX_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         word_ff <= word_in;
         rem_ff  <= rem_in;
         src_ff  <= in_src;
         pend_ff <= in_pend;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_rem   = rem_ff;
   assign out_src   = src_ff;
   assign out_pend  = pend_ff;

endmodule
`default_nettype wire

[src/bsi_mac_cell.sv]
// Dimension close-out cell: scales the coordinate by the source stride and accumulates.
`timescale 1ns / 1ps
`default_nettype none
module bsi_mac_cell
   import bsi_pkg::*;
#(
   parameter int INDEX_BITS  = 32,
   parameter int EXTENT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [INDEX_BITS-1:0]  stride,
   input  wire logic                   bcast,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire logic [INDEX_BITS-1:0]  in_word,
   input  wire logic [EXTENT_BITS-1:0] in_rem,
   input  wire logic [INDEX_BITS-1:0]  in_src,
   input  wire logic [INDEX_BITS-1:0]  in_pend,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      logic [INDEX_BITS-1:0]  out_word,
   output      logic [EXTENT_BITS-1:0] out_rem,
   output      logic [INDEX_BITS-1:0]  out_src,
   output      logic [INDEX_BITS-1:0]  out_pend
);

   logic                              valid_ff, valid_in;
   logic [INDEX_BITS-1:0]             word_ff, src_ff, src_in, pend_ff, pend_in;
   logic [EXTENT_BITS+INDEX_BITS-1:0] prod;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // previous product is added while this one is formed
   always_comb begin
      prod    = {{INDEX_BITS{1'b0}}, in_rem} * {{EXTENT_BITS{1'b0}}, stride};
      pend_in = bcast ? '0 : prod[INDEX_BITS-1:0];
      src_in  = in_src + in_pend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         word_ff <= in_word;
         src_ff  <= src_in;
         pend_ff <= pend_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_rem   = '0;   // fresh remainder for the next division
   assign out_src   = src_ff;
   assign out_pend  = pend_ff;

endmodule
`default_nettype wire

[src/bsi_shape.sv]
// Shape registers and per-dimension divisors, broadcast marks and source strides.
`timescale 1ns / 1ps
`default_nettype none
module bsi_shape
   import bsi_pkg::*;
#(
   parameter int MAX_DIMS    = 4,
   parameter int EXTENT_BITS = 16,
   parameter int INDEX_BITS  = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]             csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]              csr_wdata,
   output      logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  divisor,
   output      logic [MAX_DIMS-1:0][INDEX_BITS-1:0]   stride,
   output      logic [MAX_DIMS-1:0]                   bcast,
   output      logic                                  shape_err
);

   localparam int PAD_BITS = MAX_DIMS * EXTENT_BITS + CSR_DATA_BITS;

   logic [RANK_BITS-1:0]     trank_ff, srank_ff;
   logic [CSR_DATA_BITS-1:0] text_ff, sext_ff;

   logic [PAD_BITS-1:0]                 tpad, spad;
   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] tdim_in, sdim_in;
   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] tdim_ff, sdim_ff;
   logic [MAX_DIMS-1:0]                  bcast_in, bcast_ff;
   logic                                 err_in, err_ff;
   logic [MAX_DIMS-1:0][INDEX_BITS-1:0]  stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trank_ff <= RANK_BITS'(1);
         srank_ff <= RANK_BITS'(1);
         text_ff  <= CSR_DATA_BITS'(1);
         sext_ff  <= CSR_DATA_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_RANK:    trank_ff <= csr_wdata[RANK_BITS-1:0];
            CSR_SOURCE_RANK:    srank_ff <= csr_wdata[RANK_BITS-1:0];
            CSR_TARGET_EXTENTS: text_ff  <= csr_wdata;
            CSR_SOURCE_EXTENTS: sext_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // dimension j counts from the innermost; fields past the register read as zero
   assign tpad = {{(MAX_DIMS*EXTENT_BITS){1'b0}}, text_ff};
   assign spad = {{(MAX_DIMS*EXTENT_BITS){1'b0}}, sext_ff};

   always_comb begin
      err_in = (trank_ff == '0) || (int'(trank_ff) > MAX_DIMS) || (srank_ff > trank_ff);
      for (int j = 0; j < MAX_DIMS; j++) begin
         tdim_in[j] = EXTENT_BITS'(1);
         sdim_in[j] = EXTENT_BITS'(1);
         for (int i = 0; i < MAX_DIMS; i++) begin
            if (int'(trank_ff) == i + j + 1) begin
               tdim_in[j] = tpad[EXTENT_BITS*i +: EXTENT_BITS];
            end
            if (int'(srank_ff) == i + j + 1) begin
               sdim_in[j] = spad[EXTENT_BITS*i +: EXTENT_BITS];
            end
         end
         if (j < int'(trank_ff) && (tdim_in[j] == '0 || sdim_in[j] == '0)) begin
            err_in = 1'b1;
         end
         bcast_in[j] = (sdim_in[j] == EXTENT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      tdim_ff  <= tdim_in;
      sdim_ff  <= sdim_in;
      bcast_ff <= bcast_in;
      err_ff   <= err_in;
   end

   // source strides, one multiply per stage, innermost outward
   logic [EXTENT_BITS+INDEX_BITS-1:0] sprod [MAX_DIMS];
   assign stride_ff[0] = INDEX_BITS'(1);
   assign sprod[0]     = '0;
   for (genvar j = 1; j < MAX_DIMS; j++) begin : g_stride
      assign sprod[j] = {{EXTENT_BITS{1'b0}}, stride_ff[j-1]}
                      * {{INDEX_BITS{1'b0}}, sdim_ff[j-1]};
      always_ff @(posedge clock) begin
         stride_ff[j] <= sprod[j][INDEX_BITS-1:0];
      end
   end

   assign divisor   = tdim_ff;
   assign stride    = stride_ff;
   assign bcast     = bcast_ff;
   assign shape_err = err_ff | (|sprod[0]);

endmodule
`default_nettype wire

[src/broadcast_source_index_unit.sv]
// Top level: broadcast index mapper built as a chain of division and accumulate cells.
// The chain has one restoring-division cell per index bit and dimension.
// Throughput: one beat per cycle unless rsp_ready stalls; every cell holds its own beat.
// Reset: synchronous, active high; empties the chain and sets all shape registers to 1.
// Stride products settle after a register write, ahead of any beat accepted after it.
`timescale 1ns / 1ps
`default_nettype none
module broadcast_source_index_unit
   import bsi_pkg::*;
#(
   parameter int MAX_DIMS    = 4,
   parameter int EXTENT_BITS = 16,
   parameter int INDEX_BITS  = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic [INDEX_BITS-1:0]     req_target_index,
   // response channel
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic [INDEX_BITS-1:0]     rsp_source_index,
   output      logic                      rsp_index_beyond_size,
   output      logic                      rsp_shape_error,
   // configuration
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // node n is the output of the n-th cell; per dimension IB div cells then one mac cell
   localparam int SEG  = INDEX_BITS + 1;
   localparam int LAST = MAX_DIMS * SEG;

   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] divisor;
   logic [MAX_DIMS-1:0][INDEX_BITS-1:0]  stride;
   logic [MAX_DIMS-1:0]                  bcast;
   logic                                 shape_err;

   logic [LAST:0]          n_valid, n_ready;
   logic [INDEX_BITS-1:0]  n_word [0:LAST];
   logic [EXTENT_BITS-1:0] n_rem  [0:LAST];
   logic [INDEX_BITS-1:0]  n_src  [0:LAST];
   logic [INDEX_BITS-1:0]  n_pend [0:LAST];

   bsi_shape #(
      .MAX_DIMS   (MAX_DIMS),
      .EXTENT_BITS(EXTENT_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_shape (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .divisor  (divisor),
      .stride   (stride),
      .bcast    (bcast),
      .shape_err(shape_err)
   );

   // entry cell: registers the request beat, contributes nothing
   bsi_mac_cell #(
      .INDEX_BITS (INDEX_BITS),
      .EXTENT_BITS(EXTENT_BITS)
   ) u_entry (
      .clock    (clock),
      .reset    (reset),
      .stride   ('0),
      .bcast    (1'b1),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_word  (req_target_index),
      .in_rem   ('0),
      .in_src   ('0),
      .in_pend  ('0),
      .out_valid(n_valid[0]),
      .out_ready(n_ready[0]),
      .out_word (n_word[0]),
      .out_rem  (n_rem[0]),
      .out_src  (n_src[0]),
      .out_pend (n_pend[0])
   );

   for (genvar j = 0; j < MAX_DIMS; j++) begin : g_dim
      for (genvar s = 0; s < INDEX_BITS; s++) begin : g_step
         localparam int I = j * SEG + s;
         bsi_div_cell #(
            .INDEX_BITS (INDEX_BITS),
            .EXTENT_BITS(EXTENT_BITS)
         ) u_div (
            .clock    (clock),
            .reset    (reset),
            .divisor  (divisor[j]),
            .in_valid (n_valid[I]),
            .in_ready (n_ready[I]),
            .in_word  (n_word[I]),
            .in_rem   (n_rem[I]),
            .in_src   (n_src[I]),
            .in_pend  (n_pend[I]),
            .out_valid(n_valid[I+1]),
            .out_ready(n_ready[I+1]),
            .out_word (n_word[I+1]),
            .out_rem  (n_rem[I+1]),
            .out_src  (n_src[I+1]),
            .out_pend (n_pend[I+1])
         );
      end

      // remainder is this dimension's coordinate, quotient feeds the next one out
      localparam int M = j * SEG + INDEX_BITS;
      bsi_mac_cell #(
         .INDEX_BITS (INDEX_BITS),
         .EXTENT_BITS(EXTENT_BITS)
      ) u_mac (
         .clock    (clock),
         .reset    (reset),
         .stride   (stride[j]),
         .bcast    (bcast[j]),
         .in_valid (n_valid[M]),
         .in_ready (n_ready[M]),
         .in_word  (n_word[M]),
         .in_rem   (n_rem[M]),
         .in_src   (n_src[M]),
         .in_pend  (n_pend[M]),
         .out_valid(n_valid[M+1]),
         .out_ready(n_ready[M+1]),
         .out_word (n_word[M+1]),
         .out_rem  (n_rem[M+1]),
         .out_src  (n_src[M+1]),
         .out_pend (n_pend[M+1])
      );
   end

   // output register; a quotient left over after all dimensions means out of range
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0] src_ff, src_in;
   logic                  beyond_ff, beyond_in;
   logic                  err_ff;
   logic                  take;

   assign n_ready[LAST] = !rsp_valid_ff || rsp_ready;
   assign take          = n_valid[LAST] && n_ready[LAST];
   assign rsp_valid_in  = take || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      beyond_in = !shape_err && (n_word[LAST] != '0);
      src_in    = (shape_err || beyond_in) ? '0 : n_src[LAST] + n_pend[LAST];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         src_ff    <= src_in;
         beyond_ff <= beyond_in;
         err_ff    <= shape_err;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_source_index      = src_ff;
   assign rsp_index_beyond_size = beyond_ff;
   assign rsp_shape_error       = err_ff;

endmodule
`default_nettype wire

[bench/broadcast_source_index_unit_tb.sv]
// Testbench for the broadcast source index unit: directed table, then random beats.
`timescale 1ns / 1ps
`default_nettype none
module broadcast_source_index_unit_tb;
   import bsi_pkg::*;

   localparam int LATENCY     = 4 * 33 + 2;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 1030;

   typedef struct packed {
      logic [31:0] source_index;
      logic        beyond;
      logic        shape_err;
   } mapped_type;

   typedef struct {
      logic [31:0] target_index;
      bit          typed;     // expected value written in the row
      mapped_type  result;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_target_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_source_index;
   logic        rsp_index_beyond_size;
   logic        rsp_shape_error;
   logic        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_TARGET_RANK;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   broadcast_source_index_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_target_index(req_target_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_source_index(rsp_source_index),
      .rsp_index_beyond_size(rsp_index_beyond_size),
      .rsp_shape_error(rsp_shape_error),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the shape registers
   logic [2:0]  sh_trank = 3'd1;
   logic [2:0]  sh_srank = 3'd1;
   logic [63:0] sh_text  = 64'd1;
   logic [63:0] sh_sext  = 64'd1;

   mapped_type pending_map[$];
   int         errors = 0;
   int         cycles = 0;
   bit         quiet_rx = 1'b0;   // no idling stretch
   bit         hold_rx  = 1'b0;   // long receiver hold-off

   // expected mapping of one target index under the shadow shape
   function automatic mapped_type map_index(logic [31:0] tidx);
      mapped_type  m;
      logic [63:0] text[4];
      logic [63:0] sext[4];
      logic [63:0] size, rem, coord;
      logic [31:0] stride, src;
      int          tr, sr, pad;
      m = '0;
      tr = sh_trank;
      sr = sh_srank;
      if (tr == 0 || tr > 4 || sr > tr) begin
         m.shape_err = 1'b1;
         return m;
      end
      pad = tr - sr;
      for (int d = 0; d < tr; d++) begin
         text[d] = 64'(sh_text[16*d +: 16]);
         sext[d] = (d < pad) ? 64'd1 : 64'(sh_sext[16*(d-pad) +: 16]);
         if (text[d] == 0 || sext[d] == 0) m.shape_err = 1'b1;
      end
      if (m.shape_err) return m;
      // at most four 16-bit factors: never overflows 64 bits
      size = 64'd1;
      for (int d = 0; d < tr; d++) size = size * text[d];
      if (64'(tidx) >= size) begin
         m.beyond = 1'b1;
         return m;
      end
      rem = 64'(tidx);
      stride = 32'd1;
      src = '0;
      for (int d = tr - 1; d >= 0; d--) begin
         coord = rem % text[d];
         rem   = rem / text[d];
         if (sext[d] != 1) src = src + 32'(coord) * stride;
         stride = stride * 32'(sext[d]);
      end
      m.source_index = src;
      return m;
   endfunction

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TARGET_RANK:    sh_trank = val[2:0];
         CSR_SOURCE_RANK:    sh_srank = val[2:0];
         CSR_TARGET_EXTENTS: sh_text  = val;
         default:            sh_sext  = val;
      endcase
   endtask

   task automatic set_shape(logic [63:0] tr, logic [63:0] sr, logic [63:0] te, logic [63:0] se);
      csr_write(CSR_TARGET_RANK, tr);
      csr_write(CSR_SOURCE_RANK, sr);
      csr_write(CSR_TARGET_EXTENTS, te);
      csr_write(CSR_SOURCE_EXTENTS, se);
      // let the stride products settle
      repeat (8) @(negedge clock);
   endtask

   // drop valid, wait until every pending mapping has returned, then for the pipe to drain
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_map.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // offer one beat; the expectation is queued when it is taken.
   // valid stays high after the beat unless the next call idles or drain drops it
   task automatic send_beat(logic [31:0] tidx, bit may_idle, bit typed, mapped_type typed_res);
      mapped_type m;
      if (may_idle)
         while ($urandom_range(99) < 21) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      m = typed ? typed_res : map_index(tidx);
      req_valid        <= 1'b1;
      req_target_index <= tidx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_map.push_back(m);
      @(negedge clock);
   endtask

   // receiver: ready changes on the falling edge only
   always @(negedge clock) begin
      if (hold_rx)        rsp_ready <= 1'b0;
      else if (quiet_rx)  rsp_ready <= 1'b1;
      else                rsp_ready <= ($urandom_range(99) >= 21);
   end

   // response checker
   always @(posedge clock) begin
      mapped_type exp_m;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_map.size() == 0) begin
            $display("%0t: response beat with nothing expected: src=%h b=%b e=%b", $time,
               rsp_source_index, rsp_index_beyond_size, rsp_shape_error);
            errors++;
         end else begin
            exp_m = pending_map.pop_front();
            if (rsp_source_index !== exp_m.source_index) begin
               $display("%0t: source_index expected %h actual %h", $time,
                  exp_m.source_index, rsp_source_index);
               errors++;
            end
            if (rsp_index_beyond_size !== exp_m.beyond) begin
               $display("%0t: index_beyond_size expected %b actual %b", $time,
                  exp_m.beyond, rsp_index_beyond_size);
               errors++;
            end
            if (rsp_shape_error !== exp_m.shape_err) begin
               $display("%0t: shape_error expected %b actual %b", $time,
                  exp_m.shape_err, rsp_shape_error);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // long hold-off counted in its own process while the sender keeps pushing
   task automatic receiver_hold(int n);
      hold_rx = 1'b1;
      repeat (n) @(negedge clock);
      hold_rx = 1'b0;
   endtask

   // random shape: mostly small extents, a few large ones
   function automatic logic [63:0] rand_extents(bit allow_zero);
      logic [63:0] v;
      for (int d = 0; d < 4; d++) begin
         case ($urandom_range(9))
            0:       v[16*d +: 16] = allow_zero ? 16'd0 : 16'd1;
            1:       v[16*d +: 16] = 16'($urandom);
            2:       v[16*d +: 16] = 16'hFFFF;
            3, 4:    v[16*d +: 16] = 16'd1;
            default: v[16*d +: 16] = 16'($urandom_range(2, 9));
         endcase
      end
      return v;
   endfunction

   stim_row_type rows[$];
   mapped_type   zero_m;

   task automatic run_rows();
      foreach (rows[i]) send_beat(rows[i].target_index, 1'b1, rows[i].typed, rows[i].result);
      rows.delete();
   endtask

   function automatic stim_row_type row(logic [31:0] t, bit typed, mapped_type r);
      stim_row_type s;
      s.target_index = t;
      s.typed = typed;
      s.result = r;
      return s;
   endfunction

   initial begin
      mapped_type  beyond_m, err_m;
      logic [63:0] te, se;
      int          tr, sr, n_sent, phase_len;
      zero_m   = '0;
      beyond_m = '0; beyond_m.beyond = 1'b1;
      err_m    = '0; err_m.shape_err = 1'b1;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // after reset: a 1-element target, every index but 0 lies beyond
      rows.push_back(row(32'd0, 1'b1, zero_m));
      rows.push_back(row(32'd1, 1'b1, beyond_m));
      rows.push_back(row(32'hFFFFFFFF, 1'b1, beyond_m));
      run_rows();
      drain();

      // full-size 4-d target, source broadcast in the middle dims
      set_shape(4, 4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_0001_0001_FFFF);
      rows.push_back(row(32'd0, 1'b1, zero_m));
      rows.push_back(row(32'hFFFFFFFF, 1'b0, zero_m));
      rows.push_back(row(32'h5555AAAA, 1'b0, zero_m));
      rows.push_back(row(32'hAAAA5555, 1'b0, zero_m));
      run_rows();
      drain();

      // scalar source: every index in range maps to 0
      set_shape(3, 0, 64'h0000_0005_0004_0003, 64'h0);
      rows.push_back(row(32'd59, 1'b1, zero_m));
      rows.push_back(row(32'd60, 1'b1, beyond_m));
      run_rows();
      drain();

      // source rank above target rank
      set_shape(2, 3, 64'h0000_0000_0004_0003, 64'h0000_0001_0004_0003);
      rows.push_back(row(32'd5, 1'b1, err_m));
      run_rows();
      drain();

      // target rank 0 and rank above the limit
      set_shape(0, 0, 64'd7, 64'd7);
      rows.push_back(row(32'd0, 1'b1, err_m));
      run_rows();
      drain();
      set_shape(7, 1, 64'd7, 64'd7);
      rows.push_back(row(32'd3, 1'b1, err_m));
      run_rows();
      drain();

      // zero extent in the target, then in the source
      set_shape(2, 2, 64'h0000_0000_0000_0003, 64'h0000_0000_0001_0003);
      rows.push_back(row(32'd1, 1'b1, err_m));
      run_rows();
      drain();
      set_shape(2, 1, 64'h0000_0000_0005_0003, 64'h0);
      rows.push_back(row(32'hFFFFFFFF, 1'b1, err_m));
      run_rows();
      drain();

      // incompatible extents, padded source
      set_shape(3, 2, 64'h0000_0006_0004_0003, 64'h0000_0000_0005_0002);
      for (int k = 0; k < 6; k++) rows.push_back(row(32'(k * 13), 1'b0, zero_m));
      rows.push_back(row(32'd72, 1'b1, beyond_m));
      run_rows();
      drain();

      // random phases over many shapes
      n_sent = 0;
      while (n_sent < N_RANDOM) begin
         tr = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
         sr = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(0, tr);
         te = rand_extents($urandom_range(7) == 0);
         se = rand_extents($urandom_range(7) == 0);
         set_shape(tr, sr, te, se);
         quiet_rx = ($urandom_range(5) == 0);
         // first phase offers more beats than the chain holds, under a long hold-off
         phase_len = (n_sent == 0) ? 2 * LATENCY : $urandom_range(20, 60);
         if (n_sent == 0) fork receiver_hold(LATENCY * 3); join_none
         for (int k = 0; k < phase_len; k++) begin
            logic [31:0] t;
            case ($urandom_range(5))
               0:       t = $urandom;
               1:       t = $urandom_range(0, 1000);
               default: t = $urandom_range(0, 200);
            endcase
            send_beat(t, !quiet_rx, 1'b0, zero_m);
         end
         n_sent += phase_len;
         quiet_rx = 1'b0;
         // sender pauses until every result is back before the next shape
         drain();
      end

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // leftovers are caught by drain above: any still pending here is a failure
   always @(posedge clock) begin
      if (cycles == CYCLE_LIMIT && pending_map.size() != 0) errors++;
   end

endmodule
`default_nettype wire
